FILE: rtl/twm_pkg.sv
// Shared constants, types and helpers for the threshold warning monitor.
package twm_pkg;

  localparam int FIELDS_DEF       = 16;
  localparam int MAX_WARNINGS_DEF = 8;

  localparam logic [7:0]  HOLD_RST    = 8'd50;
  localparam logic [15:0] MIN_RPM_RST = 16'd500;
  localparam logic [7:0]  ROTATE_RST  = 8'd5;
  localparam logic [7:0]  LATCH_RST   = 8'd100;
  localparam logic signed [15:0] DIS_LIMIT_RST = -16'sd32768;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_HIGH = 2'd1;
  localparam logic [1:0] KIND_LOW  = 2'd2;

  typedef enum logic [2:0] {
    REG_STARTUP_HOLD = 3'd0,
    REG_MIN_RPM      = 3'd1,
    REG_ROTATE       = 3'd2,
    REG_LATCH        = 3'd3,
    REG_DIS_LIMIT    = 3'd4
  } cfg_reg_t;

  // list entry: field in bits 3..0, bit 4 set for a low warning
  typedef logic [4:0] entry_t;

  function automatic logic [9:0] dec_scale(input logic [1:0] s);
    logic [9:0] r;
    case (s)
      2'd0:    r = 10'd1;
      2'd1:    r = 10'd10;
      2'd2:    r = 10'd100;
      default: r = 10'd1000;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/threshold_warning_monitor.sv
// Threshold warning monitor: per-field limit checks and end-of-scan warning display state.
//
// Usage: a scan is a run of input words, one per monitored field, with
// last_field set on the closing word. Input and output channels use
// valid/stall; a word moves on a rising edge with valid high and stall low.
// Configuration is a separate valid/ready write port (cfg_index, cfg_data),
// always ready; write it only while the block is idle.
// Each input word is registered, then compared and folded into the scan state
// as it leaves the input register. One output word appears per closing word,
// registered in the output register; other words produce no output.
// Throughput is one input word per cycle while the output is not stalled,
// set by the single compare and update stage between the input register and
// the output register. When the receiver stalls, the output word holds; a
// further closing word then waits in the input register and in_stall rises,
// while non-closing words keep flowing. Reset is synchronous: configuration
// returns to its defaults, the start-up hold-off restarts at 50 scans, all
// scan and display state clears. The start-up hold register is accepted on
// the port but only its reset value governs the hold-off.
module threshold_warning_monitor
  import twm_pkg::*;
#(
  parameter int FIELDS       = FIELDS_DEF,
  parameter int MAX_WARNINGS = MAX_WARNINGS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         field_number,
  input  logic               field_enabled,
  input  logic signed [23:0] raw_value,
  input  logic [1:0]         dec_places,
  input  logic               high_enable,
  input  logic signed [15:0] high_limit,
  input  logic               low_enable,
  input  logic signed [15:0] low_limit,
  input  logic [15:0]        engine_rpm,
  input  logic               config_valid,
  input  logic               last_field,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               warning_on,
  output logic [3:0]         shown_field,
  output logic [1:0]         shown_kind,
  output logic               text_changed,
  output logic [3:0]         warning_count
);

  localparam int CW   = $clog2(MAX_WARNINGS + 1);
  localparam int IDXW = (MAX_WARNINGS > 1) ? $clog2(MAX_WARNINGS) : 1;
  localparam logic [CW-1:0] MAXW = CW'(MAX_WARNINGS);

  // configuration
  logic [15:0]        min_rpm;
  logic [7:0]         rotate_scans;
  logic [7:0]         latch_scans;
  logic signed [15:0] dis_limit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_rpm      <= MIN_RPM_RST;
      rotate_scans <= ROTATE_RST;
      latch_scans  <= LATCH_RST;
      dis_limit    <= DIS_LIMIT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_STARTUP_HOLD: ;
        REG_MIN_RPM:      min_rpm      <= cfg_data;
        REG_ROTATE:       rotate_scans <= cfg_data[7:0];
        REG_LATCH:        latch_scans  <= cfg_data[7:0];
        REG_DIS_LIMIT:    dis_limit    <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // input register
  logic               s_valid;
  logic [3:0]         s_field;
  logic               s_en;
  logic signed [23:0] s_raw;
  logic [1:0]         s_shift;
  logic               s_he;
  logic signed [15:0] s_hl;
  logic               s_le;
  logic signed [15:0] s_ll;
  logic [15:0]        s_rpm;
  logic               s_cv;
  logic               s_last;

  logic res_free, advance, fire, in_acc;

  assign res_free = !out_valid || !out_stall;
  assign advance  = !s_valid || !s_last || res_free;
  assign in_stall = s_valid && !advance;
  assign in_acc   = in_valid && !in_stall;
  assign fire     = s_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_acc) begin
      s_valid <= 1'b1;
    end else if (advance) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s_field <= field_number;
      s_en    <= field_enabled;
      s_raw   <= raw_value;
      s_shift <= dec_places;
      s_he    <= high_enable;
      s_hl    <= high_limit;
      s_le    <= low_enable;
      s_ll    <= low_limit;
      s_rpm   <= engine_rpm;
      s_cv    <= config_valid;
      s_last  <= last_field;
    end
  end

  // scan and display state
  logic [7:0]      hold_counter;
  entry_t          scan_list [MAX_WARNINGS];
  entry_t          warn_list [MAX_WARNINGS];
  logic [CW-1:0]   scan_count;
  logic [CW-1:0]   active_count;
  logic [CW-1:0]   latched_count;
  logic [IDXW-1:0] show_index;
  logic [7:0]      rotate_counter;
  logic [7:0]      latch_counter;
  logic            active_flag;
  logic [3:0]      shown_fld;
  logic [1:0]      shown_knd;

  logic [7:0]      hold_counter_next;
  logic [CW-1:0]   scan_count_next;
  logic [CW-1:0]   active_count_next;
  logic [CW-1:0]   latched_count_next;
  logic [IDXW-1:0] show_index_next;
  logic [7:0]      rotate_counter_next;
  logic [7:0]      latch_counter_next;
  logic            active_flag_next;
  logic [3:0]      shown_fld_next;
  logic [1:0]      shown_knd_next;
  logic            changed;
  logic            copy_list;

  // limit compare
  logic signed [26:0] scale_x, raw_x, hi_prod, lo_prod;
  logic               hi_hit, lo_hit, take;
  logic               append;
  entry_t             new_entry;
  entry_t             scan_upd [MAX_WARNINGS];
  logic [CW-1:0]      n;

  assign scale_x = $signed(27'(dec_scale(s_shift)));
  assign raw_x   = 27'(s_raw);
  assign hi_prod = 27'(s_hl) * scale_x;
  assign lo_prod = 27'(s_ll) * scale_x;
  assign hi_hit  = s_he && (s_hl > dis_limit) && (raw_x > hi_prod);
  assign lo_hit  = s_le && (s_rpm >= min_rpm) && (s_ll > dis_limit) && (raw_x < lo_prod);
  assign take    = (scan_count < MAXW) && s_en && (7'(s_field) < 7'(FIELDS));
  assign append  = take && (hi_hit || lo_hit);
  assign new_entry = {!hi_hit, s_field};
  assign n       = append ? scan_count + CW'(1) : scan_count;

  always_comb begin
    for (int i = 0; i < MAX_WARNINGS; i++) begin
      scan_upd[i] = scan_list[i];
    end
    if (append) begin
      scan_upd[scan_count[IDXW-1:0]] = new_entry;
    end
  end

  // end-of-scan update
  always_comb begin
    logic [IDXW-1:0] si;
    logic [7:0]      rc;
    logic [IDXW:0]   si_inc;
    logic            rotated;
    entry_t          e;
    si = show_index;
    rc = rotate_counter;
    si_inc = '0;
    rotated = 1'b0;
    e = '0;
    hold_counter_next   = hold_counter;
    scan_count_next     = n;
    active_count_next   = active_count;
    latched_count_next  = latched_count;
    show_index_next     = show_index;
    rotate_counter_next = rotate_counter;
    latch_counter_next  = latch_counter;
    active_flag_next    = active_flag;
    shown_fld_next      = shown_fld;
    shown_knd_next      = shown_knd;
    changed             = 1'b0;
    copy_list           = 1'b0;
    if (s_last) begin
      scan_count_next = '0;
      if (hold_counter != 8'd0) begin
        hold_counter_next = hold_counter - 8'd1;
        active_flag_next  = 1'b0;
        active_count_next = '0;
      end else if (!s_cv) begin
        active_flag_next  = 1'b0;
        active_count_next = '0;
      end else if (n != '0) begin
        if (n != active_count) begin
          si = '0;
          rc = '0;
        end
        if (CW'(si) >= n) si = '0;
        copy_list = 1'b1;
        active_count_next = n;
        if (n > CW'(1)) begin
          rc = rc + 8'd1;
          if (rc >= rotate_scans) begin
            rc = '0;
            si_inc = (IDXW+1)'(si) + (IDXW+1)'(1);
            si = (CW'(si_inc) >= n) ? '0 : si_inc[IDXW-1:0];
            rotated = 1'b1;
          end
        end
        changed = rotated || !active_flag;
        if (changed) begin
          e = scan_upd[si];
          shown_fld_next = e[3:0];
          shown_knd_next = e[4] ? KIND_LOW : KIND_HIGH;
        end
        show_index_next     = si;
        rotate_counter_next = rc;
        active_flag_next    = 1'b1;
        latched_count_next  = n;
        latch_counter_next  = latch_scans;
      end else if (latch_counter != 8'd0) begin
        latch_counter_next = latch_counter - 8'd1;
        active_count_next  = latched_count;
        if (latched_count > CW'(1)) begin
          if (CW'(si) >= latched_count) si = '0;
          rc = rc + 8'd1;
          if (rc >= rotate_scans) begin
            rc = '0;
            si_inc = (IDXW+1)'(si) + (IDXW+1)'(1);
            si = (CW'(si_inc) >= latched_count) ? '0 : si_inc[IDXW-1:0];
            e = warn_list[si];
            shown_fld_next = e[3:0];
            shown_knd_next = e[4] ? KIND_LOW : KIND_HIGH;
          end
          show_index_next     = si;
          rotate_counter_next = rc;
        end
        active_flag_next = 1'b1;
      end else begin
        active_flag_next    = 1'b0;
        shown_fld_next      = '0;
        shown_knd_next      = KIND_NONE;
        active_count_next   = '0;
        latched_count_next  = '0;
        show_index_next     = '0;
        rotate_counter_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_counter   <= HOLD_RST;
      scan_count     <= '0;
      active_count   <= '0;
      latched_count  <= '0;
      show_index     <= '0;
      rotate_counter <= '0;
      latch_counter  <= '0;
      active_flag    <= 1'b0;
      shown_fld      <= '0;
      shown_knd      <= KIND_NONE;
    end else if (fire) begin
      hold_counter   <= hold_counter_next;
      scan_count     <= scan_count_next;
      active_count   <= active_count_next;
      latched_count  <= latched_count_next;
      show_index     <= show_index_next;
      rotate_counter <= rotate_counter_next;
      latch_counter  <= latch_counter_next;
      active_flag    <= active_flag_next;
      shown_fld      <= shown_fld_next;
      shown_knd      <= shown_knd_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && append) begin
      scan_list[scan_count[IDXW-1:0]] <= new_entry;
    end
    if (fire && copy_list) begin
      for (int i = 0; i < MAX_WARNINGS; i++) begin
        warn_list[i] <= scan_upd[i];
      end
    end
  end

  // output register
  logic [7:0] ac_wide;
  assign ac_wide = 8'(active_count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && s_last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && s_last) begin
      warning_on    <= active_flag_next;
      shown_field   <= shown_fld_next;
      shown_kind    <= shown_knd_next;
      text_changed  <= changed;
      warning_count <= ac_wide[3:0];
    end
  end

endmodule

FILE: bench/threshold_warning_monitor_test.sv
// Self-checking bench for the threshold warning monitor: scans, display predictor, random stalls.
module threshold_warning_monitor_test;
  timeunit 1ns;
  timeprecision 1ps;
  import twm_pkg::*;

  typedef struct packed {
    logic [3:0]         field_number;
    logic               field_enabled;
    logic signed [23:0] raw_value;
    logic [1:0]         dec_places;
    logic               high_enable;
    logic signed [15:0] high_limit;
    logic               low_enable;
    logic signed [15:0] low_limit;
    logic [15:0]        engine_rpm;
    logic               config_valid;
    logic               last_field;
  } field_word_t;

  typedef struct packed {
    logic       warning_on;
    logic [3:0] shown_field;
    logic [1:0] shown_kind;
    logic       text_changed;
    logic [3:0] warning_count;
  } display_t;

  typedef struct packed {
    logic [7:0]         hold;
    logic [15:0]        min_rpm;
    logic [7:0]         rotate;
    logic [7:0]         latch;
    logic signed [15:0] dis;
  } setting_t;

  class warning_board;
    logic [7:0]  hold_scans, rotate_scans, latch_scans;
    logic [15:0] min_rpm;
    int          dis_limit;
    logic [7:0]  hold_cnt, rot_cnt, latch_cnt;
    entry_t      scan_list[MAX_WARNINGS_DEF];
    entry_t      warn_list[MAX_WARNINGS_DEF];
    int          scan_n, active_n, latched_n, show_idx;
    bit          active;
    logic [3:0]  shown_field;
    logic [1:0]  shown_kind;
    display_t    display_q[$];
    int          errors;

    function void clear();
      hold_scans   = HOLD_RST;
      min_rpm      = MIN_RPM_RST;
      rotate_scans = ROTATE_RST;
      latch_scans  = LATCH_RST;
      dis_limit    = DIS_LIMIT_RST;
      hold_cnt     = HOLD_RST;
      rot_cnt      = 8'd0;
      latch_cnt    = 8'd0;
      scan_n       = 0;
      active_n     = 0;
      latched_n    = 0;
      show_idx     = 0;
      active       = 1'b0;
      shown_field  = 4'd0;
      shown_kind   = KIND_NONE;
      errors       = 0;
      display_q.delete();
    endfunction

    // hold_scans only matters at reset, which is never repeated
    function void set_reg(cfg_reg_t r, logic [15:0] d);
      case (r)
        REG_STARTUP_HOLD: hold_scans = d[7:0];
        REG_MIN_RPM:      min_rpm = d;
        REG_ROTATE:       rotate_scans = d[7:0];
        REG_LATCH:        latch_scans = d[7:0];
        REG_DIS_LIMIT:    dis_limit = $signed(d);
        default: ;
      endcase
    endfunction

    function bit step_rotation(int n);
      rot_cnt = rot_cnt + 8'd1;
      if (rot_cnt >= rotate_scans) begin
        rot_cnt = 8'd0;
        show_idx++;
        if (show_idx >= n) show_idx = 0;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void show(entry_t e);
      shown_field = e[3:0];
      shown_kind  = e[4] ? KIND_LOW : KIND_HIGH;
    endfunction

    function void fold_field(field_word_t w);
      longint   scale, raw, hi, lo;
      display_t d;
      bit       changed;
      int       n;
      case (w.dec_places)
        2'd0:    scale = 1;
        2'd1:    scale = 10;
        2'd2:    scale = 100;
        default: scale = 1000;
      endcase
      raw = $signed(w.raw_value);
      hi  = $signed(w.high_limit);
      lo  = $signed(w.low_limit);
      changed = 1'b0;
      if (scan_n < MAX_WARNINGS_DEF && w.field_enabled && w.field_number < FIELDS_DEF) begin
        if (w.high_enable && hi > dis_limit && raw > hi * scale) begin
          scan_list[scan_n] = {1'b0, w.field_number};
          scan_n++;
        end else if (w.low_enable && w.engine_rpm >= min_rpm && lo > dis_limit &&
                     raw < lo * scale) begin
          scan_list[scan_n] = {1'b1, w.field_number};
          scan_n++;
        end
      end
      if (!w.last_field) return;
      n = scan_n;
      scan_n = 0;
      if (hold_cnt > 8'd0) begin
        hold_cnt = hold_cnt - 8'd1;
        active   = 1'b0;
        active_n = 0;
      end else if (!w.config_valid) begin
        active   = 1'b0;
        active_n = 0;
      end else if (n > 0) begin
        if (n != active_n) begin
          show_idx = 0;
          rot_cnt  = 8'd0;
        end
        if (show_idx >= n) show_idx = 0;
        for (int i = 0; i < n; i++) warn_list[i] = scan_list[i];
        active_n = n;
        if (n > 1) changed = step_rotation(n);
        if (!active) begin
          show(warn_list[show_idx]);
          changed = 1'b1;
        end else if (changed) begin
          show(warn_list[show_idx]);
        end
        active    = 1'b1;
        latched_n = n;
        latch_cnt = latch_scans;
      end else if (latch_cnt > 8'd0) begin
        latch_cnt = latch_cnt - 8'd1;
        active_n  = latched_n;
        if (active_n > 1) begin
          if (show_idx >= active_n) show_idx = 0;
          if (step_rotation(active_n)) show(warn_list[show_idx]);
        end
        active = 1'b1;
      end else begin
        active      = 1'b0;
        shown_field = 4'd0;
        shown_kind  = KIND_NONE;
        active_n    = 0;
        latched_n   = 0;
        show_idx    = 0;
        rot_cnt     = 8'd0;
      end
      d.warning_on    = active;
      d.shown_field   = shown_field;
      d.shown_kind    = shown_kind;
      d.text_changed  = changed;
      d.warning_count = active_n[3:0];
      display_q.push_back(d);
    endfunction

    function void check_one(string what, logic [3:0] want, logic [3:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
      end
    endfunction

    function void match_display(display_t got);
      display_t want;
      if (display_q.size() == 0) begin
        errors++;
        $display("%0t: display word with none expected: on %0d field %0d kind %0d chg %0d cnt %0d",
                 $time, got.warning_on, got.shown_field, got.shown_kind, got.text_changed,
                 got.warning_count);
        return;
      end
      want = display_q.pop_front();
      check_one("warning_on", want.warning_on, got.warning_on);
      check_one("shown_field", want.shown_field, got.shown_field);
      check_one("shown_kind", want.shown_kind, got.shown_kind);
      check_one("text_changed", want.text_changed, got.text_changed);
      check_one("warning_count", want.warning_count, got.warning_count);
    endfunction

    function int pending();
      return display_q.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = 3'd0;
  logic [15:0]        cfg_data = 16'd0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [3:0]         field_number = 4'd0;
  logic               field_enabled = 1'b0;
  logic signed [23:0] raw_value = 24'sd0;
  logic [1:0]         dec_places = 2'd0;
  logic               high_enable = 1'b0;
  logic signed [15:0] high_limit = 16'sd0;
  logic               low_enable = 1'b0;
  logic signed [15:0] low_limit = 16'sd0;
  logic [15:0]        engine_rpm = 16'd0;
  logic               config_valid = 1'b0;
  logic               last_field = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               warning_on;
  logic [3:0]         shown_field;
  logic [1:0]         shown_kind;
  logic               text_changed;
  logic [3:0]         warning_count;

  warning_board sb;
  field_word_t  pattern_q[$];
  logic [15:0]  cur_min_rpm;
  int           cur_dis;
  int           idle_pct = 31;
  int           phase_words;
  int           displays_seen = 0;

  threshold_warning_monitor dut (.*);

  always #10 clk = ~clk;

  function automatic field_word_t mk(logic [3:0] f, logic en, int raw, logic [1:0] sh,
                                     logic he, int hl, logic le, int ll, logic [15:0] rpm,
                                     logic cv, logic last);
    field_word_t w;
    w.field_number  = f;
    w.field_enabled = en;
    w.raw_value     = raw[23:0];
    w.dec_places    = sh;
    w.high_enable   = he;
    w.high_limit    = hl[15:0];
    w.low_enable    = le;
    w.low_limit     = ll[15:0];
    w.engine_rpm    = rpm;
    w.config_valid  = cv;
    w.last_field    = last;
    return w;
  endfunction

  // value placed on, just past or between the limits
  function automatic field_word_t limit_word(logic [3:0] f, logic [15:0] rpm, bit warn,
                                             bit last);
    logic [1:0] sh;
    int         scale, hl, ll, raw;
    sh = 2'($urandom_range(3));
    scale = (sh == 2'd0) ? 1 : (sh == 2'd1) ? 10 : (sh == 2'd2) ? 100 : 1000;
    hl = int'($urandom_range(400)) - 200;
    ll = hl - int'($urandom_range(300));
    if ($urandom_range(15) == 0) hl = cur_dis;
    if ($urandom_range(15) == 0) ll = cur_dis;
    if (warn)
      raw = $urandom_range(1) ? hl * scale + int'($urandom_range(1, 3))
                              : ll * scale - int'($urandom_range(1, 3));
    else if (hl > ll && $urandom_range(2) == 0)
      raw = ll * scale + int'($urandom_range((hl - ll) * scale));
    else
      raw = $urandom_range(1) ? hl * scale : ll * scale;
    return mk(f, $urandom_range(19) != 0, raw, sh, $urandom_range(7) != 0, hl,
              $urandom_range(7) != 0, ll, rpm, $urandom_range(12) != 0, last);
  endfunction

  function automatic field_word_t noise_word(bit last);
    logic [95:0] bits;
    field_word_t w;
    bits = {$urandom, $urandom, $urandom};
    w = bits[82:0];
    w.last_field = last;
    return w;
  endfunction

  function automatic void fresh_pattern();
    int          len;
    bit          mixed;
    logic [15:0] rpm, r;
    pattern_q.delete();
    len = ($urandom_range(99) < 85) ? int'($urandom_range(1, 5)) : int'($urandom_range(6, 12));
    case ($urandom_range(2))
      0:       rpm = cur_min_rpm;
      1:       rpm = cur_min_rpm - 16'd1;
      default: rpm = 16'($urandom);
    endcase
    mixed = ($urandom_range(9) == 0);
    for (int i = 0; i < len; i++) begin
      r = mixed ? ($urandom_range(1) ? cur_min_rpm : cur_min_rpm - 16'd1) : rpm;
      pattern_q.push_back(limit_word(4'($urandom_range(15)), r, $urandom_range(99) < 40,
                                     i == len - 1));
    end
  endfunction

  task automatic send_word(field_word_t w);
    in_valid      <= 1'b1;
    field_number  <= w.field_number;
    field_enabled <= w.field_enabled;
    raw_value     <= w.raw_value;
    dec_places    <= w.dec_places;
    high_enable   <= w.high_enable;
    high_limit    <= w.high_limit;
    low_enable    <= w.low_enable;
    low_limit     <= w.low_limit;
    engine_rpm    <= w.engine_rpm;
    config_valid  <= w.config_valid;
    last_field    <= w.last_field;
    do @(posedge clk); while (in_stall);
    sb.fold_field(w);
    phase_words++;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // mostly repeated scans so warnings persist, rotate and latch
  task automatic send_scan();
    field_word_t scan[$];
    int          mode, k;
    mode = $urandom_range(99);
    if (mode < 10) begin
      k = $urandom_range(1, 5);
      for (int i = 0; i < k; i++) scan.push_back(noise_word(i == k - 1));
    end else begin
      if (mode >= 65 || pattern_q.size() == 0) fresh_pattern();
      scan = pattern_q;
      if ($urandom_range(4) == 0) begin
        k = $urandom_range(scan.size() - 1);
        scan[k] = limit_word(scan[k].field_number, scan[k].engine_rpm, $urandom_range(1),
                             scan[k].last_field);
      end
    end
    foreach (scan[i]) send_word(scan[i]);
  endtask

  task automatic send_directed();
    field_word_t d[$];
    d.push_back(mk(4'd15, 1, 8388607, 2'd0, 1, 32767, 0, 0, 16'd0, 1, 1));
    d.push_back(mk(4'd0, 1, -8388608, 2'd3, 0, 0, 1, -8000, 16'd500, 1, 1));
    // low limit at the disabled value, then high and low both true
    d.push_back(mk(4'd1, 1, -8388608, 2'd0, 0, 0, 1, -32768, 16'd65535, 1, 0));
    d.push_back(mk(4'd2, 1, 0, 2'd0, 1, -10, 1, 10, 16'd65535, 1, 1));
    // rpm per word, disabled field, no checks enabled
    d.push_back(mk(4'd3, 1, -5, 2'd1, 0, 0, 1, 0, 16'd499, 1, 0));
    d.push_back(mk(4'd4, 1, -1, 2'd2, 0, 0, 1, 0, 16'd500, 1, 0));
    d.push_back(mk(4'd5, 0, 8388607, 2'd0, 1, 0, 1, 0, 16'd500, 1, 0));
    d.push_back(mk(4'd6, 1, 8388607, 2'd0, 0, 0, 0, 0, 16'd500, 1, 1));
    d.push_back(mk(4'd7, 1, 1000, 2'd0, 1, 999, 0, 0, 16'd500, 0, 1));
    d.push_back(mk(4'd8, 1, 1000, 2'd3, 1, 1, 0, 0, 16'd500, 1, 0));
    d.push_back(mk(4'd9, 1, 1001, 2'd3, 1, 1, 0, 0, 16'd500, 1, 1));
    for (int i = 0; i < 10; i++)
      d.push_back(mk(i[3:0], 1, 100, 2'd0, 1, 0, 0, 0, 16'd500, 1, i == 9));
    foreach (d[i]) send_word(d[i]);
  endtask

  task automatic put_reg(cfg_reg_t r, logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(r, v);
  endtask

  task automatic load_settings(setting_t s);
    put_reg(REG_STARTUP_HOLD, {8'd0, s.hold});
    put_reg(REG_MIN_RPM, s.min_rpm);
    put_reg(REG_ROTATE, {8'd0, s.rotate});
    put_reg(REG_LATCH, {8'd0, s.latch});
    put_reg(REG_DIS_LIMIT, s.dis);
    cfg_valid   <= 1'b0;
    cur_min_rpm = s.min_rpm;
    cur_dis     = s.dis;
  endtask

  task automatic settle();
    while (sb.pending() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    setting_t plan[5];
    sb = new;
    sb.clear();
    plan[0] = '{8'd255, 16'd0, 8'd1, 8'd0, -16'sd32768};
    plan[1] = '{8'd0, 16'd65535, 8'd255, 8'd255, 16'sd0};
    plan[2] = '{8'd7, 16'd300, 8'd2, 8'd3, 16'sd32767};
    plan[3] = '{8'd100, 16'd1000, 8'd3, 8'd10, -16'sd32767};
    plan[4] = '{8'd50, 16'd500, 8'd0, 8'd1, -16'sd100};
    cur_min_rpm = MIN_RPM_RST;
    cur_dis     = DIS_LIMIT_RST;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    for (int p = 0; p < 6; p++) begin
      if (p > 0) begin
        settle();
        load_settings(plan[p - 1]);
      end
      idle_pct    = (p == 4) ? 0 : 31;
      phase_words = 0;
      if (p == 0) begin
        repeat (50) send_scan();
        send_directed();
      end
      while (phase_words < 330) send_scan();
      in_valid <= 1'b0;
    end
    for (int w = 0; w < 20000 && sb.pending() > 0; w++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.pending() > 0) begin
      $display("%0t: %0d display words never arrived", $time, sb.pending());
      sb.errors += sb.pending();
    end
    if (sb.errors == 0)
      $display("** threshold_warning_monitor: PASSED **");
    else
      $display("** threshold_warning_monitor: FAILED **");
    $finish;
  end

  // receiver: random stalls plus one long hold-off so the block backs up
  initial begin
    display_t d;
    int       held_for;
    bit       pressed;
    held_for = 0;
    pressed  = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        d.warning_on    = warning_on;
        d.shown_field   = shown_field;
        d.shown_kind    = shown_kind;
        d.text_changed  = text_changed;
        d.warning_count = warning_count;
        sb.match_display(d);
        displays_seen++;
      end
      if (!pressed && displays_seen >= 150) begin
        pressed  = 1'b1;
        held_for = 300;
      end
      if (held_for > 0) begin
        held_for--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < idle_pct);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("** threshold_warning_monitor: FAILED **");
    $finish;
  end

endmodule
